FILE: src/buddy_block_allocator_macros.svh
// assertion macros for the buddy block allocator
`ifndef BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define BBA_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define BBA_ASSERT(lbl, prop, msg) `BBA_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define BBA_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define BBA_ASSERT(lbl, prop, msg)
`endif
`endif

FILE: src/bba_pkg.sv
// shared types and constants of the buddy block allocator
package bba_pkg;

  localparam int unsigned MAX_TREE_LEVELS_DEF = 10;
  localparam int unsigned OFFSET_BITS_DEF     = 32;

  localparam logic [4:0] MAX_LOG2_RST = 5'd20;
  localparam logic [4:0] MIN_LOG2_RST = 5'd10;

  // configuration register indexes
  localparam logic REG_MAX_BLOCK_LOG2 = 1'b0;
  localparam logic REG_MIN_BLOCK_LOG2 = 1'b1;

  typedef enum logic [1:0] {
    ST_ABSENT = 2'd0,
    ST_FREE   = 2'd1,
    ST_SPLIT  = 2'd2,
    ST_ALLOC  = 2'd3
  } node_st_e;

  typedef enum logic [1:0] {
    RES_DONE      = 2'd0,
    RES_BAD_SIZE  = 2'd1,
    RES_NO_FREE   = 2'd2,
    RES_NOT_ALLOC = 2'd3
  } res_st_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_ACCEPT,
    CMD_SCAN_STEP,
    CMD_SCAN_NEXT,
    CMD_SCAN_TAKE,
    CMD_SPLIT_P,
    CMD_SPLIT_R,
    CMD_SPLIT_L,
    CMD_ALLOC_POST,
    CMD_MERGE_RD,
    CMD_MERGE_ABS,
    CMD_MERGE_UP,
    CMD_WALK_DESC,
    CMD_FREE_POST,
    CMD_POST_ERR
  } dp_cmd_e;

  typedef struct packed {
    dp_cmd_e cmd;
    res_st_e err;
  } dp_ctl_t;

  typedef struct packed {
    logic     is_free;
    logic     bad_size;
    logic     level_done;
    logic     best_any;
    logic     lv_zero;
    logic     lvl_lt_want;
    logic     lvl_zero;
    logic     walk_more;
    logic     clr_last;
    node_st_e rd_state;
  } dp_sts_t;

endpackage

FILE: src/bba_ram.sv
// generic one-write one-read ram with registered read
module bba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/bba_ctrl.sv
// sequencing state machine of the buddy block allocator
`include "buddy_block_allocator_macros.svh"
module bba_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  bba_pkg::dp_sts_t sts_i,
  output bba_pkg::dp_ctl_t ctl_o
);
  import bba_pkg::*;

  typedef enum logic [14:0] {
    S_CLEAR     = 15'b000000000000001,
    S_IDLE      = 15'b000000000000010,
    S_DISPATCH  = 15'b000000000000100,
    S_SCAN      = 15'b000000000001000,
    S_SPLIT_CHK = 15'b000000000010000,
    S_SPLIT_P   = 15'b000000000100000,
    S_SPLIT_R   = 15'b000000001000000,
    S_SPLIT_L   = 15'b000000010000000,
    S_ALLOC     = 15'b000000100000000,
    S_WALK_RD   = 15'b000001000000000,
    S_WALK_EV   = 15'b000010000000000,
    S_MERGE_RD  = 15'b000100000000000,
    S_MERGE_EV  = 15'b001000000000000,
    S_MERGE_W2  = 15'b010000000000000,
    S_FREE_W    = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  // next state and datapath command
  always_comb begin
    state_d   = state_q;
    ctl_o.cmd = CMD_NONE;
    ctl_o.err = RES_DONE;
    case (state_q)
      S_CLEAR: begin
        ctl_o.cmd = CMD_CLEAR;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          ctl_o.cmd = CMD_ACCEPT;
          state_d   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts_i.is_free) begin
          state_d = S_WALK_RD;
        end else if (sts_i.bad_size) begin
          ctl_o.cmd = CMD_POST_ERR;
          ctl_o.err = RES_BAD_SIZE;
          state_d   = S_IDLE;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!sts_i.level_done) begin
          ctl_o.cmd = CMD_SCAN_STEP;
        end else if (sts_i.best_any) begin
          ctl_o.cmd = CMD_SCAN_TAKE;
          state_d   = S_SPLIT_CHK;
        end else if (sts_i.lv_zero) begin
          ctl_o.cmd = CMD_POST_ERR;
          ctl_o.err = RES_NO_FREE;
          state_d   = S_IDLE;
        end else begin
          ctl_o.cmd = CMD_SCAN_NEXT;
        end
      end
      S_SPLIT_CHK: begin
        state_d = sts_i.lvl_lt_want ? S_SPLIT_P : S_ALLOC;
      end
      S_SPLIT_P: begin
        ctl_o.cmd = CMD_SPLIT_P;
        state_d   = S_SPLIT_R;
      end
      S_SPLIT_R: begin
        ctl_o.cmd = CMD_SPLIT_R;
        state_d   = S_SPLIT_L;
      end
      S_SPLIT_L: begin
        ctl_o.cmd = CMD_SPLIT_L;
        state_d   = S_SPLIT_CHK;
      end
      S_ALLOC: begin
        ctl_o.cmd = CMD_ALLOC_POST;
        state_d   = S_IDLE;
      end
      S_WALK_RD: begin
        state_d = S_WALK_EV;
      end
      S_WALK_EV: begin
        if ((sts_i.rd_state == ST_SPLIT) && sts_i.walk_more) begin
          ctl_o.cmd = CMD_WALK_DESC;
          state_d   = S_WALK_RD;
        end else if (sts_i.rd_state == ST_ALLOC) begin
          state_d = S_MERGE_RD;
        end else begin
          ctl_o.cmd = CMD_POST_ERR;
          ctl_o.err = RES_NOT_ALLOC;
          state_d   = S_IDLE;
        end
      end
      S_MERGE_RD: begin
        if (sts_i.lvl_zero) begin
          state_d = S_FREE_W;
        end else begin
          ctl_o.cmd = CMD_MERGE_RD;
          state_d   = S_MERGE_EV;
        end
      end
      S_MERGE_EV: begin
        if (sts_i.rd_state == ST_FREE) begin
          ctl_o.cmd = CMD_MERGE_ABS;
          state_d   = S_MERGE_W2;
        end else begin
          state_d = S_FREE_W;
        end
      end
      S_MERGE_W2: begin
        ctl_o.cmd = CMD_MERGE_UP;
        state_d   = S_MERGE_RD;
      end
      S_FREE_W: begin
        ctl_o.cmd = CMD_FREE_POST;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register, clearing pass follows reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  `BBA_ASSERT(a_accept_busy, (start_i && !busy_o) |=> busy_o, "accepted word did not raise busy")
  `BBA_ASSERT(a_scan_alloc, (state_q == S_SCAN) |-> !sts_i.is_free, "level scan on a free request")

endmodule

FILE: src/bba_dpath.sv
// tree memories, counters and result registers of the buddy block allocator
`include "buddy_block_allocator_macros.svh"
module bba_dpath #(
  parameter int unsigned MAX_TREE_LEVELS = bba_pkg::MAX_TREE_LEVELS_DEF,
  parameter int unsigned OFFSET_BITS     = bba_pkg::OFFSET_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bba_pkg::dp_ctl_t ctl_i,
  output bba_pkg::dp_sts_t sts_o,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [4:0]       cfg_wdata_i,
  input  logic             op_i,
  input  logic [5:0]       size_log2_i,
  input  logic [31:0]      offset_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic [31:0]      block_offset_o,
  output logic [4:0]       block_size_log2_o
);
  import bba_pkg::*;

  localparam int unsigned NODES = (2 ** (MAX_TREE_LEVELS + 1)) - 1;
  localparam int unsigned NW    = MAX_TREE_LEVELS + 1;
  localparam int unsigned LW    = $clog2(MAX_TREE_LEVELS + 1);
  localparam int unsigned PW    = MAX_TREE_LEVELS;
  localparam int unsigned SHW   = MAX_TREE_LEVELS + 32;

  // control registers
  logic [4:0]    max_q, min_q;
  logic [31:0]   cnt_q, cnt_d;
  logic [NW-1:0] clr_q, clr_d;
  logic          done_q, done_d;
  logic          vld_q, vld_d;
  logic [NW-1:0] idx_q, idx_d;
  logic [LW-1:0] lvl_q, lvl_d;

  // working registers
  logic          op_q, op_d;
  logic          bad_q, bad_d;
  logic [4:0]    s_q, s_d;
  logic [LW-1:0] want_q, want_d;
  logic [LW-1:0] lv_q, lv_d;
  logic [NW-1:0] rpos_q, rpos_d;
  logic [PW-1:0] vpos_q, vpos_d;
  logic          any_q, any_d;
  logic [31:0]   best_age_q, best_age_d;
  logic [PW-1:0] best_pos_q, best_pos_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [31:0]   off_q, off_d;
  logic [31:0]   node_off_q, node_off_d;
  logic [1:0]    res_st_q, res_st_d;
  logic [31:0]   res_off_q, res_off_d;
  logic [4:0]    res_sz_q, res_sz_d;

  // memory ports
  logic          st_we, sp_we;
  logic [NW-1:0] waddr, raddr;
  logic [1:0]    st_wdata, st_rdata;
  logic [31:0]   sp_wdata, sp_rdata;

  // helpers
  logic [5:0]    s6, diff6, lvl6;
  logic [NW-1:0] first_lv, count_lv, scan_addr;
  logic [NW-1:0] idx_left, idx_right, idx_buddy, idx_parent;
  logic [31:0]   age, half, off_mask;
  logic [32:0]   bound;
  logic          better, has_half, go_left;
  logic [4:0]    hsh;
  logic [SHW-1:0] sh_full;
  node_st_e      rd_st;

  bba_ram #(.WIDTH(2), .DEPTH(NODES)) u_state_ram (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(waddr),
    .wdata_i(st_wdata),
    .raddr_i(raddr),
    .rdata_o(st_rdata)
  );

  bba_ram #(.WIDTH(32), .DEPTH(NODES)) u_stamp_ram (
    .clk_i  (clk_i),
    .we_i   (sp_we),
    .waddr_i(waddr),
    .wdata_i(sp_wdata),
    .raddr_i(raddr),
    .rdata_o(sp_rdata)
  );

  // address arithmetic and small compares
  always_comb begin
    for (int b = 0; b < 32; b++) begin
      off_mask[b] = (b < OFFSET_BITS);
    end
    s6         = (size_log2_i < {1'b0, min_q}) ? {1'b0, min_q} : size_log2_i;
    diff6      = {1'b0, max_q} - s6;
    first_lv   = (NW'(1) << lv_q) - NW'(1);
    count_lv   = NW'(1) << lv_q;
    scan_addr  = first_lv + rpos_q;
    idx_left   = (idx_q << 1) + NW'(1);
    idx_right  = (idx_q << 1) + NW'(2);
    idx_buddy  = idx_q[0] ? (idx_q + NW'(1)) : (idx_q - NW'(1));
    idx_parent = (idx_q - NW'(1)) >> 1;
    rd_st      = node_st_e'(st_rdata);
    age        = cnt_q - sp_rdata;
    better     = (rd_st == ST_FREE) && (!any_q || (age < best_age_q));
    lvl6       = 6'(lvl_q);
    has_half   = ({1'b0, max_q} >= (lvl6 + 6'd1));
    hsh        = 5'({1'b0, max_q} - lvl6 - 6'd1);
    half       = has_half ? (32'd1 << hsh) : 32'd0;
    bound      = {1'b0, node_off_q} + {1'b0, half};
    go_left    = ({1'b0, off_q} < bound);
    sh_full    = SHW'(pos_q) << s_q;
  end

  // command decode
  always_comb begin
    cnt_d      = cnt_q;
    clr_d      = clr_q;
    done_d     = 1'b0;
    vld_d      = 1'b0;
    idx_d      = idx_q;
    lvl_d      = lvl_q;
    op_d       = op_q;
    bad_d      = bad_q;
    s_d        = s_q;
    want_d     = want_q;
    lv_d       = lv_q;
    rpos_d     = rpos_q;
    vpos_d     = vpos_q;
    any_d      = any_q;
    best_age_d = best_age_q;
    best_pos_d = best_pos_q;
    pos_d      = pos_q;
    off_d      = off_q;
    node_off_d = node_off_q;
    res_st_d   = res_st_q;
    res_off_d  = res_off_q;
    res_sz_d   = res_sz_q;
    st_we      = 1'b0;
    sp_we      = 1'b0;
    waddr      = idx_q;
    st_wdata   = ST_ABSENT;
    sp_wdata   = cnt_q + 32'd1;
    raddr      = idx_q;
    case (ctl_i.cmd)
      CMD_CLEAR: begin
        st_we    = 1'b1;
        sp_we    = 1'b1;
        waddr    = clr_q;
        st_wdata = (clr_q == '0) ? ST_FREE : ST_ABSENT;
        sp_wdata = 32'd0;
        clr_d    = clr_q + NW'(1);
      end
      CMD_ACCEPT: begin
        op_d       = op_i;
        bad_d      = (s6 > {1'b0, max_q}) || (diff6 > 6'(MAX_TREE_LEVELS));
        s_d        = s6[4:0];
        want_d     = diff6[LW-1:0];
        lv_d       = diff6[LW-1:0];
        rpos_d     = '0;
        any_d      = 1'b0;
        idx_d      = '0;
        lvl_d      = '0;
        node_off_d = '0;
        off_d      = offset_i & off_mask;
      end
      CMD_SCAN_STEP: begin
        // stream reads over the level, judge each word in the following cycle
        if (rpos_q != count_lv) begin
          raddr  = scan_addr;
          vld_d  = 1'b1;
          vpos_d = rpos_q[PW-1:0];
          rpos_d = rpos_q + NW'(1);
        end
        if (vld_q && better) begin
          any_d      = 1'b1;
          best_age_d = age;
          best_pos_d = vpos_q;
        end
      end
      CMD_SCAN_NEXT: begin
        lv_d   = lv_q - LW'(1);
        rpos_d = '0;
      end
      CMD_SCAN_TAKE: begin
        idx_d = first_lv + NW'(best_pos_q);
        lvl_d = lv_q;
        pos_d = best_pos_q;
      end
      CMD_SPLIT_P: begin
        st_we    = 1'b1;
        st_wdata = ST_SPLIT;
      end
      CMD_SPLIT_R: begin
        st_we    = 1'b1;
        sp_we    = 1'b1;
        waddr    = idx_right;
        st_wdata = ST_FREE;
        cnt_d    = cnt_q + 32'd1;
      end
      CMD_SPLIT_L: begin
        st_we    = 1'b1;
        sp_we    = 1'b1;
        waddr    = idx_left;
        st_wdata = ST_FREE;
        cnt_d    = cnt_q + 32'd1;
        idx_d    = idx_left;
        lvl_d    = lvl_q + LW'(1);
        pos_d    = pos_q << 1;
      end
      CMD_ALLOC_POST: begin
        st_we     = 1'b1;
        st_wdata  = ST_ALLOC;
        done_d    = 1'b1;
        res_st_d  = RES_DONE;
        res_off_d = sh_full[31:0] & off_mask;
        res_sz_d  = s_q;
      end
      CMD_WALK_DESC: begin
        idx_d = go_left ? idx_left : idx_right;
        lvl_d = lvl_q + LW'(1);
        if (!go_left) begin
          node_off_d = bound[31:0];
        end
      end
      CMD_MERGE_RD: begin
        raddr = idx_buddy;
      end
      CMD_MERGE_ABS: begin
        st_we    = 1'b1;
        waddr    = idx_buddy;
        st_wdata = ST_ABSENT;
      end
      CMD_MERGE_UP: begin
        st_we    = 1'b1;
        st_wdata = ST_ABSENT;
        idx_d    = idx_parent;
        lvl_d    = lvl_q - LW'(1);
      end
      CMD_FREE_POST: begin
        st_we     = 1'b1;
        sp_we     = 1'b1;
        st_wdata  = ST_FREE;
        cnt_d     = cnt_q + 32'd1;
        done_d    = 1'b1;
        res_st_d  = RES_DONE;
        res_off_d = '0;
        res_sz_d  = '0;
      end
      CMD_POST_ERR: begin
        done_d    = 1'b1;
        res_st_d  = ctl_i.err;
        res_off_d = '0;
        res_sz_d  = '0;
      end
      default: begin
      end
    endcase
  end

  // control state with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q  <= MAX_LOG2_RST;
      min_q  <= MIN_LOG2_RST;
      cnt_q  <= '0;
      clr_q  <= '0;
      done_q <= 1'b0;
      vld_q  <= 1'b0;
      idx_q  <= '0;
      lvl_q  <= '0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == REG_MAX_BLOCK_LOG2)) begin
        max_q <= cfg_wdata_i;
      end
      if (cfg_we_i && (cfg_idx_i == REG_MIN_BLOCK_LOG2)) begin
        min_q <= cfg_wdata_i;
      end
      cnt_q  <= cnt_d;
      clr_q  <= clr_d;
      done_q <= done_d;
      vld_q  <= vld_d;
      idx_q  <= idx_d;
      lvl_q  <= lvl_d;
    end
  end

  // working and result registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    bad_q      <= bad_d;
    s_q        <= s_d;
    want_q     <= want_d;
    lv_q       <= lv_d;
    rpos_q     <= rpos_d;
    vpos_q     <= vpos_d;
    any_q      <= any_d;
    best_age_q <= best_age_d;
    best_pos_q <= best_pos_d;
    pos_q      <= pos_d;
    off_q      <= off_d;
    node_off_q <= node_off_d;
    res_st_q   <= res_st_d;
    res_off_q  <= res_off_d;
    res_sz_q   <= res_sz_d;
  end

  // status towards the controller
  always_comb begin
    sts_o.is_free     = op_q;
    sts_o.bad_size    = bad_q;
    sts_o.level_done  = (rpos_q == count_lv) && !vld_q;
    sts_o.best_any    = any_q;
    sts_o.lv_zero     = (lv_q == '0);
    sts_o.lvl_lt_want = (lvl_q < want_q);
    sts_o.lvl_zero    = (lvl_q == '0);
    sts_o.walk_more   = (lvl_q < LW'(MAX_TREE_LEVELS));
    sts_o.clr_last    = (clr_q == NW'(NODES - 1));
    sts_o.rd_state    = rd_st;
  end

  assign done_o            = done_q;
  assign status_o          = res_st_q;
  assign block_offset_o    = res_off_q;
  assign block_size_log2_o = res_sz_q;

  `BBA_ASSERT(a_stamp_step, (cnt_q != $past(cnt_q)) |-> (cnt_q == $past(cnt_q) + 32'd1), "stamp jumped")
  `BBA_ASSERT(a_lvl_bound, lvl_q <= LW'(MAX_TREE_LEVELS), "tree level beyond the deepest level")
  `BBA_ASSERT(a_stamp_with_state, sp_we |-> st_we, "stamp written without node state")

endmodule

FILE: src/buddy_block_allocator.sv
// binary buddy allocator top level
// Binary buddy allocator. A word is taken when start is high and busy is
// low; its one result appears on status_o, block_offset_o and
// block_size_log2_o for exactly one cycle with done_o high, and the receiver
// cannot stall it. After reset the node-state and stamp memories are swept,
// one node a cycle, over all 2^(MAX_TREE_LEVELS+1)-1 nodes (2047 by default)
// with busy high; configuration writes take effect at once and belong only
// where no request is in flight. An allocate scans the levels from the
// requested level upward until one holds a free node, splits the block that
// it takes down to the requested level and then grants it: the scan of one
// level streams through the single read port of the node memories, one node
// a cycle. A free reads each node on the walk down from the root, then merges
// with each free buddy and stops at a buddy that is not free or at the root.
// Results come back in request order.
module buddy_block_allocator #(
  parameter int unsigned MAX_TREE_LEVELS = bba_pkg::MAX_TREE_LEVELS_DEF,
  parameter int unsigned OFFSET_BITS     = bba_pkg::OFFSET_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        start,
  output logic        busy,
  input  logic        op_i,
  input  logic [5:0]  size_log2_i,
  input  logic [31:0] offset_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [31:0] block_offset_o,
  output logic [4:0]  block_size_log2_o
);
  import bba_pkg::*;

  dp_ctl_t ctl;
  dp_sts_t sts;

  // sequencer
  bba_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .busy_o (busy),
    .sts_i  (sts),
    .ctl_o  (ctl)
  );

  // tree storage and arithmetic
  bba_dpath #(
    .MAX_TREE_LEVELS(MAX_TREE_LEVELS),
    .OFFSET_BITS    (OFFSET_BITS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctl_i            (ctl),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .op_i             (op_i),
    .size_log2_i      (size_log2_i),
    .offset_i         (offset_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .block_offset_o   (block_offset_o),
    .block_size_log2_o(block_size_log2_o)
  );

endmodule
